@@ src/sctpf_pkg.sv @@
// Shared types and constants for the SYN-cookie / hop-TTL packet filter.
// Used by the channel interfaces and the top level; no dependencies.
`default_nettype none

package sctpf_pkg;

   localparam logic [31:0] COOKIE_SECRET_RESET = 32'h7F3A9C42;
   localparam int          ROT_LEFT            = 5;
   localparam int          ROT_RIGHT           = 27;

   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;

   localparam logic [1:0]  VERDICT_PASS  = 2'd0;
   localparam logic [1:0]  VERDICT_DROP  = 2'd1;
   localparam logic [1:0]  VERDICT_REPLY = 2'd2;

   localparam int          CSR_ADDR_W        = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_COOKIE_SECRET = 2'd0;

   typedef struct packed {
      logic        headers_present;
      logic [7:0]  protocol;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic        syn_flag;
      logic        ack_flag;
      logic [31:0] seq_num;
      logic [31:0] ack_num;
      logic [7:0]  hop_ttl;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [31:0] reply_seq;
      logic [31:0] reply_ack;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] source;
      logic [7:0]  hop_ttl;
   } entry_type;

   function automatic logic [31:0] rotl5(input logic [31:0] x);
      return (x << ROT_LEFT) | (x >> ROT_RIGHT);
   endfunction

endpackage

`default_nettype wire

@@ src/sctpf_if.sv @@
// Valid/ready channel interfaces for request and response of the filter.
// Depends on sctpf_pkg for the payload types.
`default_nettype none

interface sctpf_req_if;
   import sctpf_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface sctpf_rsp_if;
   import sctpf_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ src/syn_cookie_ttl_packet_filter_top.sv @@
// Path: an accepted request is registered in stages A, B and D (stage C is combinational)
// and is then written into the response queue that drives rsp_chan.
// Throughput: one request per cycle while req_chan.ready is high; a 4-stage pipeline
// plus an 8-entry response queue; per request one table read and at most one write.
// Reset: synchronous; afterwards the table is swept clear, one entry per cycle,
// through all TABLE_DEPTH entries; req_chan.ready stays low during the sweep.
// Depends on sctpf_pkg and sctpf_if.
`default_nettype none

module syn_cookie_ttl_packet_filter_top #(
   parameter int TABLE_DEPTH = 1024
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sctpf_req_if.sink                             req_chan,
   sctpf_rsp_if.source                           rsp_chan,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [sctpf_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                      pwdata,
   output logic      [31:0]                      prdata,
   output logic                                  pready
);
   import sctpf_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   // Reciprocal for the slot = src_addr mod TABLE_DEPTH reduction. The
   // quotient estimate is low by at most one, so one conditional subtract fixes it.
   localparam longint unsigned RECIP_WIDE = (64'd1 << 32) / TABLE_DEPTH;
   localparam logic [31:0]     RECIP      = 32'(RECIP_WIDE);
   localparam logic [16:0]     DEPTH_K    = 17'(TABLE_DEPTH);
   localparam logic [31:0]     DEPTH_32   = 32'(TABLE_DEPTH);
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // ------------------------------------------------------------------
   // Configuration port: one register, cookie secret at byte address 0.
   // ------------------------------------------------------------------
   logic [31:0] secret_ff;
   logic        csr_wr;

   assign csr_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_COOKIE_SECRET) ? secret_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         secret_ff <= COOKIE_SECRET_RESET;
      end else if (csr_wr && paddr == CSR_COOKIE_SECRET) begin
         secret_ff <= pwdata;
      end
   end

   // ------------------------------------------------------------------
   // Table clearing sweep after reset: write every entry invalid.
   // ------------------------------------------------------------------
   logic             clearing_ff;
   logic [IDX_W-1:0] clr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else if (clearing_ff) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == IDX_W'(TABLE_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Admission: count requests accepted but not yet delivered. The count
   // never exceeds the response queue depth, so the pipeline never stalls
   // and the queue never overflows.
   // ------------------------------------------------------------------
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             accept;
   logic             pop;

   assign req_chan.ready = !clearing_ff && (count_ff < CNT_W'(FIFO_DEPTH));
   assign accept         = req_chan.valid && req_chan.ready;
   assign pop            = rsp_chan.valid && rsp_chan.ready;
   assign count_in       = count_ff + CNT_W'(accept) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage A: register the request, start the slot reduction (multiply by
   // the reciprocal) and the first cookie round.
   // ------------------------------------------------------------------
   logic        a_valid_ff;
   req_type     a_req_ff;
   logic [63:0] a_prod_ff;
   logic [31:0] a_h1_ff;
   logic [63:0] a_prod_in;
   logic [31:0] a_h1_in;

   assign a_prod_in = 64'(req_chan.payload.src_addr) * 64'(RECIP);
   assign a_h1_in   = rotl5(secret_ff ^ req_chan.payload.src_addr)
                    + 32'(req_chan.payload.src_port);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      a_req_ff  <= req_chan.payload;
      a_prod_ff <= a_prod_in;
      a_h1_ff   <= a_h1_in;
   end

   // ------------------------------------------------------------------
   // Stage B: quotient estimate times depth, second cookie round.
   // ------------------------------------------------------------------
   logic        b_valid_ff;
   req_type     b_req_ff;
   logic [31:0] b_qd_ff;
   logic [31:0] b_h2_ff;
   logic [48:0] b_qd_full;
   logic [31:0] b_h2_in;

   assign b_qd_full = 49'(a_prod_ff[63:32]) * 49'(DEPTH_K);
   assign b_h2_in   = rotl5(a_h1_ff ^ a_req_ff.dst_addr) + 32'(a_req_ff.dst_port);

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_req_ff <= a_req_ff;
      b_qd_ff  <= b_qd_full[31:0];
      b_h2_ff  <= b_h2_in;
   end

   // ------------------------------------------------------------------
   // Stage C: finish the remainder, issue the table read, and settle the
   // TCP verdict from the finished cookie.
   // ------------------------------------------------------------------
   logic [31:0]      c_rem_raw;
   logic [31:0]      c_rem;
   logic [IDX_W-1:0] c_slot;
   logic [31:0]      c_cookie;
   logic             c_tbl_op;
   logic [1:0]       c_verdict;
   logic [31:0]      c_reply_seq;
   logic [31:0]      c_reply_ack;
   logic             c_fwd;

   assign c_rem_raw = b_req_ff.src_addr - b_qd_ff;
   assign c_rem     = (c_rem_raw >= DEPTH_32) ? c_rem_raw - DEPTH_32 : c_rem_raw;
   assign c_slot    = c_rem[IDX_W-1:0];
   assign c_cookie  = b_h2_ff ^ secret_ff;
   assign c_tbl_op  = b_req_ff.headers_present
                   && (b_req_ff.protocol != PROTO_TCP)
                   && (b_req_ff.protocol != PROTO_ICMP);

   always_comb begin
      c_verdict = VERDICT_PASS;
      if (!b_req_ff.headers_present) begin
         c_verdict = VERDICT_DROP;
      end else if (b_req_ff.protocol == PROTO_TCP) begin
         if (b_req_ff.syn_flag && !b_req_ff.ack_flag) begin
            c_verdict = VERDICT_REPLY;
         end else if (b_req_ff.ack_flag && !b_req_ff.syn_flag) begin
            c_verdict = (b_req_ff.ack_num == c_cookie + 32'd1) ? VERDICT_PASS
                                                                : VERDICT_DROP;
         end else if (b_req_ff.syn_flag && b_req_ff.ack_flag) begin
            c_verdict = VERDICT_DROP;
         end
      end
   end

   assign c_reply_seq = (c_verdict == VERDICT_REPLY) ? c_cookie : 32'd0;
   assign c_reply_ack = (c_verdict == VERDICT_REPLY) ? b_req_ff.seq_num + 32'd1 : 32'd0;

   // ------------------------------------------------------------------
   // TTL table memory: one read port (stage C address, data in stage D)
   // and one write port (stage D update or clearing sweep).
   // ------------------------------------------------------------------
   entry_type        tbl_mem [TABLE_DEPTH];
   entry_type        rd_entry_ff;

   logic             d_valid_ff;
   logic             d_tbl_op_ff;
   logic [1:0]       d_verdict_ff;
   logic [31:0]      d_reply_seq_ff;
   logic [31:0]      d_reply_ack_ff;
   logic [IDX_W-1:0] d_slot_ff;
   logic [31:0]      d_src_ff;
   logic [7:0]       d_ttl_ff;
   logic             d_fwd_ff;
   entry_type        d_fwd_entry_ff;

   entry_type        d_entry;
   entry_type        d_wr_entry;
   logic             d_hit;
   logic             d_wr_en;
   logic [1:0]       d_verdict;

   // The write from stage D lands at the same edge as the stage C read;
   // forward it when both touch the same slot.
   assign c_fwd = d_wr_en && (d_slot_ff == c_slot);

   always_ff @(posedge clock) begin
      rd_entry_ff <= tbl_mem[c_slot];
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         tbl_mem[clr_ptr_ff] <= '0;
      end else if (d_wr_en) begin
         tbl_mem[d_slot_ff] <= d_wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      d_tbl_op_ff    <= c_tbl_op;
      d_verdict_ff   <= c_verdict;
      d_reply_seq_ff <= c_reply_seq;
      d_reply_ack_ff <= c_reply_ack;
      d_slot_ff      <= c_slot;
      d_src_ff       <= b_req_ff.src_addr;
      d_ttl_ff       <= b_req_ff.hop_ttl;
      d_fwd_ff       <= c_fwd;
      d_fwd_entry_ff <= d_wr_entry;
   end

   // ------------------------------------------------------------------
   // Stage D: compare against the stored source, insert on a miss, drop
   // on a TTL mismatch.
   // ------------------------------------------------------------------
   assign d_entry    = d_fwd_ff ? d_fwd_entry_ff : rd_entry_ff;
   assign d_hit      = d_entry.valid && (d_entry.source == d_src_ff);
   assign d_wr_en    = d_valid_ff && d_tbl_op_ff && !d_hit;
   assign d_wr_entry = '{valid: 1'b1, source: d_src_ff, hop_ttl: d_ttl_ff};

   always_comb begin
      d_verdict = d_verdict_ff;
      if (d_tbl_op_ff) begin
         d_verdict = (d_hit && (d_entry.hop_ttl != d_ttl_ff)) ? VERDICT_DROP
                                                               : VERDICT_PASS;
      end
   end

   // ------------------------------------------------------------------
   // Response queue: push every finished request, pop on rsp handshake.
   // ------------------------------------------------------------------
   rsp_type        fifo_mem [FIFO_DEPTH];
   logic [PTR_W:0] wr_ptr_ff;
   logic [PTR_W:0] rd_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         if (d_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (d_valid_ff) begin
         fifo_mem[wr_ptr_ff[PTR_W-1:0]] <= '{verdict:   d_verdict,
                                            reply_seq: d_reply_seq_ff,
                                            reply_ack: d_reply_ack_ff};
      end
   end

   assign rsp_chan.valid   = (wr_ptr_ff != rd_ptr_ff);
   assign rsp_chan.payload = fifo_mem[rd_ptr_ff[PTR_W-1:0]];

endmodule

`default_nettype wire

@@ dv/tb_syn_cookie_ttl_packet_filter_top.sv @@
// Self-checking testbench for syn_cookie_ttl_packet_filter_top: it sends parsed packet headers,
// predicts each verdict with its own cookie hash and TTL table, and checks every response.
// Depends on sctpf_pkg, sctpf_if and the filter top level.

module tb_syn_cookie_ttl_packet_filter_top;
   import sctpf_pkg::*;

   localparam int          TABLE_DEPTH     = 1024;
   localparam logic [31:0] SECRET_AT_RESET = 32'h7F3A9C42;
   localparam logic [7:0]  PROTO_UDP       = 8'd17;
   localparam int          PHASES          = 6;
   localparam int          PHASE_REQUESTS  = 155;
   localparam int          POOL_SIZE       = 16;
   localparam int          FLOW_HISTORY    = 16;
   localparam int          HOLDOFF_CYCLES  = 300;
   // The reset sweep alone runs over every table entry with no handshake.
   localparam int          IDLE_LIMIT      = 4000;
   // Leave some margin for the pipeline before touching the register.
   localparam int          SETTLE_CYCLES   = 10;
   localparam int          MAX_REPORTS     = 40;

   typedef struct packed {
      logic [31:0] sa;
      logic [31:0] da;
      logic [15:0] sp;
      logic [15:0] dp;
   } flow_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Locally owned drives; the interface and the register port follow them.
   logic                  send_valid = 1'b0;
   req_type               send_data  = '0;
   logic                  take_ready = 1'b0;
   logic                  psel       = 1'b0;
   logic                  penable    = 1'b0;
   logic                  pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr      = '0;
   logic [31:0]           pwdata     = '0;
   logic [31:0]           prdata;
   logic                  pready;

   sctpf_req_if req_chan ();
   sctpf_rsp_if rsp_chan ();

   assign req_chan.valid   = send_valid;
   assign req_chan.payload = send_data;
   assign rsp_chan.ready   = take_ready;

   syn_cookie_ttl_packet_filter_top #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // Shadow of the filter: secret, TTL table, and verdicts still owed by the block.
   logic [31:0] secret_model = SECRET_AT_RESET;
   bit          slot_valid  [TABLE_DEPTH];
   logic [31:0] slot_source [TABLE_DEPTH];
   logic [7:0]  slot_ttl    [TABLE_DEPTH];
   rsp_type     verdicts_due [$];

   // Requests waiting for the driver, and recent SYN flows for the ACK half of handshakes.
   req_type     pending_req [$];
   flow_type    recent_flows [$];
   logic [31:0] src_pool [POOL_SIZE];
   logic [7:0]  ttl_pool [POOL_SIZE];

   int errors      = 0;
   int reports     = 0;
   int n_accepted  = 0;
   int n_pass      = 0;
   int n_drop      = 0;
   int n_reply     = 0;
   int n_secrets   = 0;
   int idle_cycles = 0;
   bit req_fire    = 1'b0;

   // Sender burst state and receiver stall state.
   int             burst_left   = 1;
   int             gap_left     = 0;
   bit             holdoff_req  = 1'b0;
   int             hold_left    = 0;
   int             mode_left    = 0;
   int             stall_tick   = 0;
   stall_kind_type stall_mode   = STALL_NONE;

   // Keyed rotate-xor cookie over the connection tuple, modulo 2^32.
   function automatic logic [31:0] syn_cookie(input logic [31:0] key, input flow_type f);
      logic [31:0] h;
      h = key ^ f.sa;
      h = {h[26:0], h[31:27]} + {16'd0, f.sp};
      h = h ^ f.da;
      h = {h[26:0], h[31:27]} + {16'd0, f.dp};
      return h ^ key;
   endfunction

   function automatic flow_type flow_of(input req_type r);
      flow_type f;
      f.sa = r.src_addr;
      f.da = r.dst_addr;
      f.sp = r.src_port;
      f.dp = r.dst_port;
      return f;
   endfunction

   // Compute the verdict for one accepted request and apply its table update.
   function automatic rsp_type predict_verdict(input req_type r);
      rsp_type v;
      int      slot;
      v         = '0;
      v.verdict = VERDICT_PASS;
      slot      = int'(r.src_addr % TABLE_DEPTH);
      if (!r.headers_present) begin
         v.verdict = VERDICT_DROP;
      end else if (r.protocol == PROTO_TCP) begin
         if (r.syn_flag && !r.ack_flag) begin
            v.verdict   = VERDICT_REPLY;
            v.reply_seq = syn_cookie(secret_model, flow_of(r));
            v.reply_ack = r.seq_num + 32'd1;
         end else if (r.ack_flag && !r.syn_flag) begin
            if (r.ack_num != syn_cookie(secret_model, flow_of(r)) + 32'd1)
               v.verdict = VERDICT_DROP;
         end else if (r.syn_flag && r.ack_flag) begin
            v.verdict = VERDICT_DROP;
         end
      end else if (r.protocol != PROTO_ICMP) begin
         if (slot_valid[slot] && slot_source[slot] == r.src_addr) begin
            if (slot_ttl[slot] != r.hop_ttl)
               v.verdict = VERDICT_DROP;
         end else begin
            slot_valid[slot]  = 1'b1;
            slot_source[slot] = r.src_addr;
            slot_ttl[slot]    = r.hop_ttl;
         end
      end
      return v;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.headers_present = 1'b1;
      r.protocol        = 8'($urandom_range(0, 255));
      r.src_addr        = $urandom;
      r.dst_addr        = $urandom;
      r.src_port        = 16'($urandom_range(0, 65535));
      r.dst_port        = 16'($urandom_range(0, 65535));
      r.syn_flag        = 1'($urandom_range(0, 1));
      r.ack_flag        = 1'($urandom_range(0, 1));
      r.seq_num         = $urandom;
      r.ack_num         = $urandom;
      r.hop_ttl         = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic req_type tcp_request(input flow_type f, input logic syn, input logic ack);
      req_type r;
      r          = random_request();
      r.protocol = PROTO_TCP;
      r.src_addr = f.sa;
      r.dst_addr = f.da;
      r.src_port = f.sp;
      r.dst_port = f.dp;
      r.syn_flag = syn;
      r.ack_flag = ack;
      return r;
   endfunction

   function automatic req_type ttl_request(input logic [7:0] proto, input logic [31:0] sa,
                                           input logic [7:0] ttl);
      req_type r;
      r          = random_request();
      r.protocol = proto;
      r.src_addr = sa;
      r.hop_ttl  = ttl;
      return r;
   endfunction

   // Queue one random request. Most TCP traffic forms SYN then ACK handshakes, and
   // table traffic reuses a small pool of sources so that hits, TTL changes and
   // slot evictions all come up often.
   task automatic add_random_request();
      req_type     r;
      flow_type    f;
      int          pick;
      int          k;
      logic [31:0] good_ack;
      pick = $urandom_range(0, 99);
      r    = random_request();
      if (pick < 8) begin
         r.headers_present = 1'b0;
      end else if (pick < 38) begin
         f.sa = $urandom;
         f.da = $urandom;
         f.sp = 16'($urandom_range(0, 65535));
         f.dp = 16'($urandom_range(0, 65535));
         recent_flows.push_back(f);
         if (recent_flows.size() > FLOW_HISTORY)
            recent_flows.delete(0);
         r = tcp_request(f, 1'b1, 1'b0);
      end else if (pick < 63) begin
         if (recent_flows.size() > 0)
            f = recent_flows[$urandom_range(0, recent_flows.size() - 1)];
         else
            f = flow_of(r);
         r        = tcp_request(f, 1'b0, 1'b1);
         good_ack = syn_cookie(secret_model, f) + 32'd1;
         k        = $urandom_range(0, 9);
         // Mostly a correct ACK; otherwise off by one, or left random.
         if (k < 7)
            r.ack_num = good_ack;
         else if (k < 9)
            r.ack_num = good_ack - 32'd1;
      end else if (pick < 68) begin
         r          = tcp_request(flow_of(r), 1'b0, 1'b0);
         r.syn_flag = 1'($urandom_range(0, 1));
         r.ack_flag = r.syn_flag;
      end else if (pick < 73) begin
         r.protocol = PROTO_ICMP;
      end else begin
         k = $urandom_range(0, POOL_SIZE + 3);
         if ($urandom_range(0, 9) < 6)
            r.protocol = PROTO_UDP;
         if (k < POOL_SIZE) begin
            r.src_addr = src_pool[k];
            if ($urandom_range(0, 3) != 0)
               r.hop_ttl = ttl_pool[k];
         end
      end
      pending_req.push_back(r);
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         if (reports < MAX_REPORTS) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            reports++;
         end
      end
   endtask

   // One register transfer: setup cycle, then access cycle; the transfer completes
   // at the rising edge with psel, penable and pready high.
   task automatic csr_cycle(input bit is_write, input logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= CSR_COOKIE_SECRET;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (is_write) begin
         secret_model = value;
         n_secrets++;
      end else begin
         check_field("cookie_secret readback", secret_model, prdata);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Wait until every queued request is accepted and every verdict has come back,
   // then let the pipeline settle.
   task automatic wait_idle();
      while (pending_req.size() != 0 || send_valid || verdicts_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES)
         @(posedge clock);
   endtask

   // Driver: work in bursts of random length with random gaps; hold the request
   // steady until the block takes it.
   always @(negedge clock) begin
      if (reset) begin
         send_valid <= 1'b0;
      end else if (!send_valid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            send_valid <= 1'b0;
         end else if (pending_req.size() > 0) begin
            send_data  <= pending_req.pop_front();
            send_valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               // A third of the bursts run straight into the next one.
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            send_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall on a pattern picked at random for each stretch of random length; on request,
   // hold off completely for a long stretch so that the block backs up.
   always @(negedge clock) begin
      if (holdoff_req && hold_left == 0) begin
         hold_left   = HOLDOFF_CYCLES;
         holdoff_req = 1'b0;
      end
      if (reset) begin
         take_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         take_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_kind_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 150);
         end
         mode_left--;
         stall_tick++;
         case (stall_mode)
            STALL_NONE:  take_ready <= 1'b1;
            STALL_LIGHT: take_ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: take_ready <= ($urandom_range(0, 3) == 0);
            default:     take_ready <= (stall_tick % 4 != 0);
         endcase
      end
   end

   // Monitor: check each response against the oldest owed verdict, then predict
   // the verdict for a newly accepted request.
   always @(posedge clock) begin : monitor
      rsp_type want;
      bit      rsp_fire;
      req_fire = 1'b0;
      if (!reset) begin
         req_fire = req_chan.valid && req_chan.ready;
         rsp_fire = rsp_chan.valid && rsp_chan.ready;
         if (rsp_fire) begin
            if (verdicts_due.size() == 0) begin
               errors++;
               if (reports < MAX_REPORTS) begin
                  $display("%0t: unexpected response: expected none, actual verdict %0d",
                           $time, rsp_chan.payload.verdict);
                  reports++;
               end
            end else begin
               want = verdicts_due.pop_front();
               check_field("verdict", {30'd0, want.verdict}, {30'd0, rsp_chan.payload.verdict});
               check_field("reply_seq", want.reply_seq, rsp_chan.payload.reply_seq);
               check_field("reply_ack", want.reply_ack, rsp_chan.payload.reply_ack);
            end
         end
         if (req_fire) begin
            want = predict_verdict(req_chan.payload);
            verdicts_due.push_back(want);
            n_accepted++;
            case (want.verdict)
               VERDICT_PASS: n_pass++;
               VERDICT_DROP: n_drop++;
               default:      n_reply++;
            endcase
         end
         idle_cycles = (req_fire || rsp_fire) ? 0 : idle_cycles + 1;
      end
   end

   // Watchdog: end the run if no request or response moves for too long.
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
         $display("tb_syn_cookie_ttl_packet_filter_top: done, errors");
         $finish;
      end
   end

   initial begin : stimulus
      req_type     r;
      flow_type    ones;
      flow_type    zeros;
      logic [31:0] host_a;
      logic [31:0] secret_plan [PHASES];
      int          k;
      int          ph;

      // Pair up pool sources so that each pair shares a table slot.
      for (k = 0; k < POOL_SIZE; k++) begin
         if (k % 2 == 1)
            src_pool[k] = src_pool[k - 1] ^ (32'($urandom_range(1, 4194303)) << 10);
         else
            src_pool[k] = $urandom;
         ttl_pool[k] = 8'($urandom_range(0, 255));
      end

      // Phase 0 runs on the reset secret; the rest cover both extremes and random keys.
      secret_plan[0] = SECRET_AT_RESET;
      secret_plan[1] = 32'h0000_0000;
      secret_plan[2] = 32'hFFFF_FFFF;
      secret_plan[3] = $urandom;
      secret_plan[4] = 32'h8000_0001;
      secret_plan[5] = $urandom;

      repeat (7)
         @(negedge clock);
      reset <= 1'b0;

      // Hold off until the table sweep after reset is over.
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);

      ones   = '1;
      zeros  = '0;
      host_a = 32'h0A00_0123;

      // Directed requests, all under the reset secret.
      r = tcp_request(ones, 1'b1, 1'b0);
      r.headers_present = 1'b0;                                     // truncated SYN: drop
      pending_req.push_back(r);
      r = ttl_request(PROTO_UDP, host_a, 8'd64);
      r.headers_present = 1'b0;                                     // truncated: table untouched
      pending_req.push_back(r);
      pending_req.push_back(ttl_request(PROTO_UDP, host_a, 8'd64));  // miss: insert, pass
      pending_req.push_back(ttl_request(PROTO_UDP, host_a, 8'd64));  // hit, same TTL: pass
      pending_req.push_back(ttl_request(PROTO_UDP, host_a, 8'd63));  // hit, TTL differs: drop
      pending_req.push_back(ttl_request(8'd47, host_a + TABLE_DEPTH, 8'd1)); // evict same slot
      pending_req.push_back(ttl_request(PROTO_UDP, host_a, 8'd63));  // evicted: miss again
      pending_req.push_back(ttl_request(8'hFF, 32'hFFFF_FFFF, 8'hFF));
      pending_req.push_back(ttl_request(8'h00, 32'h0000_0000, 8'h00));
      pending_req.push_back(ttl_request(8'h00, 32'h0000_0000, 8'h00));
      r = random_request();
      r.protocol = PROTO_ICMP;                                      // ICMP always passes
      pending_req.push_back(r);
      pending_req.push_back(tcp_request(ones, 1'b0, 1'b0));         // no flags: pass
      r = tcp_request(ones, 1'b1, 1'b0);
      r.seq_num = 32'hFFFF_FFFF;                                    // reply ack wraps to zero
      pending_req.push_back(r);
      r = tcp_request(zeros, 1'b1, 1'b0);
      r.seq_num = 32'h0000_0000;
      pending_req.push_back(r);
      r = tcp_request(ones, 1'b0, 1'b1);
      r.ack_num = syn_cookie(secret_model, ones) + 32'd1;           // valid cookie: pass
      pending_req.push_back(r);
      r = tcp_request(zeros, 1'b0, 1'b1);
      r.ack_num = syn_cookie(secret_model, zeros);                  // cookie off by one: drop
      pending_req.push_back(r);
      pending_req.push_back(tcp_request(ones, 1'b1, 1'b1));         // SYN-ACK: drop
      r = random_request();
      r.protocol        = PROTO_ICMP;
      r.headers_present = 1'b0;                                     // truncated ICMP: drop
      pending_req.push_back(r);

      for (ph = 0; ph < PHASES; ph++) begin
         // Change the secret only with the block drained, then read it back.
         if (ph > 0) begin
            wait_idle();
            csr_cycle(1'b1, secret_plan[ph]);
         end
         csr_cycle(1'b0, '0);
         // Stall the response side for a long stretch while requests keep coming.
         if (ph == 2)
            holdoff_req = 1'b1;
         for (k = 0; k < PHASE_REQUESTS; k++)
            add_random_request();
      end

      wait_idle();

      $display("covered %0d requests under %0d written secrets plus the reset one", n_accepted,
               n_secrets);
      $display("verdicts seen: %0d pass, %0d drop, %0d SYN-ACK reply", n_pass, n_drop, n_reply);
      if (errors == 0 && verdicts_due.size() == 0)
         $display("tb_syn_cookie_ttl_packet_filter_top: done, clean");
      else
         $display("tb_syn_cookie_ttl_packet_filter_top: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
src/sctpf_pkg.sv
src/sctpf_if.sv
src/syn_cookie_ttl_packet_filter_top.sv
dv/tb_syn_cookie_ttl_packet_filter_top.sv
